/* rtl/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg: shared definitions for the prefix expression stack evaluator
// Sizes, character codes, status codes, sequencer states and the control
// structures that pass between the top level and the divider.
// ----------------------------------------------------------------------------
package pes_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int SYM_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int STEP_W      = $clog2(DATA_W);
   localparam int RSP_TDATA_W = ((DATA_W + STATUS_W + 7) / 8) * 8;

   // ASCII codes of the characters the block understands.
   localparam logic [SYM_W-1:0] SYM_DIGIT_LO = 8'd48;
   localparam logic [SYM_W-1:0] SYM_DIGIT_HI = 8'd57;
   localparam logic [SYM_W-1:0] SYM_ADD      = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_SUB      = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_MUL      = 8'h2A;
   localparam logic [SYM_W-1:0] SYM_DIV      = 8'h2F;
   localparam logic [SYM_W-1:0] SYM_REM      = 8'h25;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_DIVZERO   = 2'd3
   } pes_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP1,
      S_GET1,
      S_POP2,
      S_GET2,
      S_EXEC,
      S_DIV,
      S_PUSH,
      S_FINISH,
      S_TOP
   } pes_state_type;

   typedef struct packed {
      logic start;
      logic want_rem;
   } pes_div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pes_div_stat_type;

   // Only the first error of an expression is kept.
   function automatic pes_status_type sticky_err(input pes_status_type cur,
                                                 input pes_status_type code);
      sticky_err = (cur == ST_OK) ? code : cur;
   endfunction

endpackage

/* rtl/pes_ram.sv */
// ----------------------------------------------------------------------------
// pes_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module pes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pes_div.sv */
// ----------------------------------------------------------------------------
// pes_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, with the
// signs applied afterwards so that quotient and remainder truncate toward
// zero. The most negative value divided by minus one wraps naturally.
// ----------------------------------------------------------------------------
module pes_div import pes_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  pes_div_ctrl_type    ctrl,
   input  logic [DATA_W-1:0]   dividend,
   input  logic [DATA_W-1:0]   divisor,
   output pes_div_stat_type    stat,
   output logic [DATA_W-1:0]   result
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic              neg_q_ff, neg_q_in;
   logic              neg_r_ff, neg_r_in;
   logic              rem_sel_ff, rem_sel_in;

   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;
   logic              fits;
   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] mag_b;
   logic [DATA_W-1:0] pick;

   assign mag_a   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
   assign mag_b   = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
   assign shifted = {r_ff, q_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, b_ff};
   assign fits    = (shifted >= {1'b0, b_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      b_in       = b_ff;
      neg_q_in   = neg_q_ff;
      neg_r_in   = neg_r_ff;
      rem_sel_in = rem_sel_ff;
      if (ctrl.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         q_in       = mag_a;
         r_in       = '0;
         b_in       = mag_b;
         neg_q_in   = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         neg_r_in   = dividend[DATA_W-1];
         rem_sel_in = ctrl.want_rem;
      end else if (busy_ff) begin
         q_in    = {q_ff[DATA_W-2:0], fits};
         r_in    = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff       <= q_in;
      r_ff       <= r_in;
      b_ff       <= b_in;
      neg_q_ff   <= neg_q_in;
      neg_r_ff   <= neg_r_in;
      rem_sel_ff <= rem_sel_in;
   end

   always_comb begin
      if (rem_sel_ff) begin
         pick   = r_ff;
         result = neg_r_ff ? (~pick + 1'b1) : pick;
      end else begin
         pick   = q_ff;
         result = neg_q_ff ? (~pick + 1'b1) : pick;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/prefix_expression_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator: operand stack evaluator for prefix text
// Evaluates a reversed prefix expression one character per request and
// returns the value and status when the character marked last is done.
// ----------------------------------------------------------------------------
// Each request carries one ASCII character of a prefix expression, already
// reversed by the sender, in req_tdata, with req_tlast marking the final
// character. A digit pushes its value onto a 128-entry operand stack held
// in a RAM; any other character pops the top (first operand) and the next
// (second operand) and, for + - * / %, pushes first op second in 32-bit
// wrapping signed arithmetic with truncating division and remainder. An
// unknown character pops two operands and pushes nothing. The first error
// of an expression is kept: overflow when a push meets a full stack,
// underflow when a pop meets an empty one, and divide by zero. After the
// last character one response returns the top of stack (zero if empty)
// and the status, and the stack starts empty again. The block takes one
// request at a time. A digit is pushed directly; an operator first pops
// both operands through the registered RAM port, and / or % with a
// nonzero divisor then waits for the 32 single-bit steps of the shared
// divider. A last character also reads the top of the stack, and waits
// first only while an earlier response has not yet been taken. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module prefix_expression_stack_evaluator import pes_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SYM_W-1:0]       req_tdata,   // [7:0] symbol
   input  logic                   req_tlast,
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [31:0] value, [33:32] status
);

   // Sequencer and stack bookkeeping.
   pes_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   pes_status_type    err_ff, err_in;

   // Current request and the operands it works on.
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              last_ff, last_in;
   logic [DATA_W-1:0] first_ff, first_in;
   logic [DATA_W-1:0] second_ff, second_in;
   logic [DATA_W-1:0] result_ff, result_in;

   // Response holding register, so a new request can be taken while the
   // previous response waits.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   pes_status_type    rsp_status_ff, rsp_status_in;

   // Stack RAM and divider hookups.
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [DATA_W-1:0] ram_rdata;
   pes_div_ctrl_type  div_ctrl;
   pes_div_stat_type  div_stat;
   logic [DATA_W-1:0] div_result;

   logic              req_fire;
   logic              in_is_digit;
   logic              stack_empty;
   logic              stack_full;
   logic              is_div_op;
   logic              is_arith_op;
   logic              rsp_slot_free;
   logic [CNT_W-1:0]  count_dec;
   logic [DATA_W-1:0] sum;
   logic [DATA_W-1:0] diff;
   logic [DATA_W-1:0] prod;

   assign req_tready    = (state_ff == S_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign in_is_digit   = (req_tdata >= SYM_DIGIT_LO) && (req_tdata <= SYM_DIGIT_HI);
   assign stack_empty   = (count_ff == '0);
   assign stack_full    = (count_ff >= CNT_W'(STACK_DEPTH));
   assign is_div_op     = (sym_ff == SYM_DIV) || (sym_ff == SYM_REM);
   assign is_arith_op   = (sym_ff == SYM_ADD) || (sym_ff == SYM_SUB) || (sym_ff == SYM_MUL);
   assign rsp_slot_free = !rsp_valid_ff || rsp_tready;
   assign count_dec     = count_ff - 1'b1;
   assign sum           = first_ff + second_ff;
   assign diff          = first_ff - second_ff;
   assign prod          = first_ff * second_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = in_is_digit ? S_PUSH : S_POP1;
            end
         end
         S_POP1: begin
            state_in = stack_empty ? S_POP2 : S_GET1;
         end
         S_GET1: begin
            state_in = S_POP2;
         end
         S_POP2: begin
            state_in = stack_empty ? S_EXEC : S_GET2;
         end
         S_GET2: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (is_div_op) begin
               state_in = (second_ff == '0) ? S_PUSH : S_DIV;
            end else if (is_arith_op) begin
               state_in = S_PUSH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (rsp_slot_free) begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath control and register next values.
   always_comb begin
      count_in      = count_ff;
      err_in        = err_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      result_in     = result_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[ADDR_W-1:0];
      // The top of the stack is always the entry just below the count.
      ram_raddr     = count_dec[ADDR_W-1:0];
      div_ctrl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sym_in    = req_tdata;
               last_in   = req_tlast;
               result_in = DATA_W'(req_tdata - SYM_DIGIT_LO);
            end
         end
         S_POP1: begin
            if (stack_empty) begin
               err_in   = sticky_err(err_ff, ST_UNDERFLOW);
               first_in = '0;
            end else begin
               count_in = count_dec;
            end
         end
         S_GET1: begin
            first_in = ram_rdata;
         end
         S_POP2: begin
            if (stack_empty) begin
               err_in    = sticky_err(err_ff, ST_UNDERFLOW);
               second_in = '0;
            end else begin
               count_in = count_dec;
            end
         end
         S_GET2: begin
            second_in = ram_rdata;
         end
         S_EXEC: begin
            if (is_div_op) begin
               if (second_ff == '0) begin
                  err_in    = sticky_err(err_ff, ST_DIVZERO);
                  result_in = '0;
               end else begin
                  div_ctrl.start    = 1'b1;
                  div_ctrl.want_rem = (sym_ff == SYM_REM);
               end
            end else if (sym_ff == SYM_ADD) begin
               result_in = sum;
            end else if (sym_ff == SYM_SUB) begin
               result_in = diff;
            end else if (sym_ff == SYM_MUL) begin
               result_in = prod;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               result_in = div_result;
            end
         end
         S_PUSH: begin
            if (stack_full) begin
               err_in = sticky_err(err_ff, ST_OVERFLOW);
            end else begin
               ram_we   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         S_TOP: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = stack_empty ? '0 : ram_rdata;
            rsp_status_in = err_ff;
            count_in      = '0;
            err_in        = ST_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      first_ff      <= first_in;
      second_ff     <= second_in;
      result_ff     <= result_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   pes_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (result_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pes_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (first_ff),
      .divisor  (second_ff),
      .stat     (div_stat),
      .result   (div_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - DATA_W - STATUS_W){1'b0}}, rsp_status_ff, rsp_value_ff};

   // The divider only runs while the sequencer waits for it.
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == S_DIV))
      else $error("divider busy outside the divide state");

   // The stack never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // A taken request always starts work.
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("accepted request did not start");

   // Finishing an expression presents a response and starts a fresh stack.
   a_top_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TOP) |=> (rsp_tvalid && (count_ff == '0) && (err_ff == ST_OK)))
      else $error("end of expression did not produce a response");

endmodule
